### design/rls_pkg.sv
// ----------------------------------------------------------------------------
// rls_pkg
// Shared types, constants and the header key table of the response length
// scanner.
// ----------------------------------------------------------------------------
package rls_pkg;

  // largest number of bytes scanned before the scan is cut off
  localparam int unsigned MAX_MESSAGE_BYTES = 16384;
  localparam int unsigned LEN_W             = $clog2(MAX_MESSAGE_BYTES + 1);

  // header key "Content-Length:"
  localparam int unsigned KEY_LEN   = 15;
  localparam int unsigned KEY_IDX_W = $clog2(KEY_LEN + 1);

  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_SP  = 8'h20;

  // line phase, one-hot
  typedef enum logic [2:0] {
    PH_TOKEN = 3'b001,
    PH_VALUE = 3'b010,
    PH_REST  = 3'b100
  } phase_e;

  // one input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // one result word
  typedef struct packed {
    logic [31:0] total_size;
    logic        length_found;
    logic        header_complete;
  } result_t;

  // per-line scan state plus the latched length
  typedef struct packed {
    phase_e                 phase;
    logic [KEY_IDX_W-1:0]   match_idx;
    logic                   has_bytes;
    logic [LEN_W-1:0]       line_bytes;
    logic [31:0]            acc;
    logic [31:0]            content_len;
    logic                   len_seen;
  } scan_t;

  // key character at a match position
  function automatic logic [7:0] key_char(logic [KEY_IDX_W-1:0] idx);
    logic [7:0] c;
    begin
      case (idx)
        4'd0:    c = "C";
        4'd1:    c = "o";
        4'd2:    c = "n";
        4'd3:    c = "t";
        4'd4:    c = "e";
        4'd5:    c = "n";
        4'd6:    c = "t";
        4'd7:    c = "-";
        4'd8:    c = "L";
        4'd9:    c = "e";
        4'd10:   c = "n";
        4'd11:   c = "g";
        4'd12:   c = "t";
        4'd13:   c = "h";
        4'd14:   c = ":";
        default: c = BYTE_NUL;
      endcase
      return c;
    end
  endfunction

endpackage

### design/http_response_length_scanner.sv
// An accepted word waits in the input register; a result word that it yields is
// then loaded into the result register.
// Throughput: one byte per cycle; the input register and the result register are
// the only stages, and both move whenever the result register is free.
// A stalled result holds the scan stage, and the input side backs up behind it.
// Reset (rst_ni low, asynchronous) clears all scan state and empties both register stages.
// ----------------------------------------------------------------------------
// http_response_length_scanner
// Scans an HTTP response byte stream for the Content-Length header and
// reports the content length plus the header length.
// ----------------------------------------------------------------------------
module http_response_length_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic [31:0] total_size_o,
  output logic        length_found_o,
  output logic        header_complete_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);
  import rls_pkg::*;

  item_t   item_in;
  item_t   item_q;
  logic    item_valid;
  logic    out_free;
  logic    advance;
  logic    emit;
  result_t res;

  assign item_in.data_byte = data_byte_i;
  assign item_in.last_byte = last_byte_i;

  // scan stage moves when it holds a word and the result register is free
  assign advance = item_valid && out_free;

  rls_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item_in),
    .take_i     (advance),
    .valid_o    (item_valid),
    .item_o     (item_q)
  );

  rls_scan_core u_scan_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .emit_o    (emit),
    .res_o     (res)
  );

  rls_out_reg u_out_reg (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (advance && emit),
    .res_i             (res),
    .free_o            (out_free),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .total_size_o      (total_size_o),
    .length_found_o    (length_found_o),
    .header_complete_o (header_complete_o)
  );

endmodule

### design/rls_in_reg.sv
// ----------------------------------------------------------------------------
// rls_in_reg
// Input register: holds one accepted word until the scan stage takes it.
// ----------------------------------------------------------------------------
module rls_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rls_pkg::item_t item_i,
  input  logic          take_i,
  output logic          valid_o,
  output rls_pkg::item_t item_o
);
  import rls_pkg::*;

  logic  valid_q;
  item_t item_q;

  // free when empty or when the held word moves on this cycle
  assign in_ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### design/rls_scan_core.sv
// ----------------------------------------------------------------------------
// rls_scan_core
// Scan state and the per-byte update: line split at CR LF, key match,
// digit accumulation and the end-of-scan decision.
// ----------------------------------------------------------------------------
module rls_scan_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  rls_pkg::item_t   item_i,
  output logic             emit_o,
  output rls_pkg::result_t res_o
);
  import rls_pkg::*;

  localparam scan_t SCAN_RESET = '{
    phase:       PH_TOKEN,
    match_idx:   '0,
    has_bytes:   1'b0,
    line_bytes:  '0,
    acc:         '0,
    content_len: '0,
    len_seen:    1'b0
  };

  scan_t            scan_q, scan_d;
  logic [LEN_W-1:0] hdr_q, hdr_d;
  logic             cr_q, cr_d;
  logic             done_q, done_d;

  // one ordinary line byte that is not a held CR
  function automatic scan_t take_byte(scan_t s, logic [7:0] b);
    scan_t r;
    begin
      r            = s;
      r.line_bytes = s.line_bytes + LEN_W'(1);
      r.has_bytes  = 1'b1;
      case (s.phase)
        PH_TOKEN: begin
          if (b == BYTE_SP) begin
            if (s.match_idx == KEY_IDX_W'(KEY_LEN)) begin
              r.phase = PH_VALUE;
              r.acc   = '0;
            end else begin
              r.phase = PH_REST;
            end
          end else if ((s.match_idx < KEY_IDX_W'(KEY_LEN)) &&
                       (b == key_char(s.match_idx))) begin
            r.match_idx = s.match_idx + KEY_IDX_W'(1);
          end else begin
            r.phase = PH_REST;
          end
        end
        PH_VALUE: begin
          if (b == BYTE_SP) begin
            r.content_len = s.acc;
            r.len_seen    = 1'b1;
            r.phase       = PH_REST;
          end else if (b inside {[8'h30:8'h39]}) begin
            r.acc = (s.acc << 3) + (s.acc << 1) + {28'd0, b[3:0]};
          end
        end
        default: ;
      endcase
      return r;
    end
  endfunction

  // next-state and result logic for the word in the input register
  always_comb begin
    logic [7:0]     b;
    logic           last;
    logic           emit;
    logic           complete;
    logic [LEN_W:0] taken;

    b        = item_i.data_byte;
    last     = item_i.last_byte;
    emit     = 1'b0;
    complete = 1'b0;
    scan_d   = scan_q;
    hdr_d    = hdr_q;
    cr_d     = cr_q;
    done_d   = done_q;
    taken    = '0;

    if (done_q) begin
      // drain until the final byte
      if (last) begin
        scan_d = SCAN_RESET;
        hdr_d  = '0;
        cr_d   = 1'b0;
        done_d = 1'b0;
      end
    end else begin
      if (b == BYTE_NUL) begin
        emit = 1'b1;
      end else if (cr_q && (b == BYTE_LF)) begin
        // line end
        cr_d = 1'b0;
        if (!scan_q.has_bytes) begin
          hdr_d    = hdr_q + LEN_W'(2);
          emit     = 1'b1;
          complete = 1'b1;
        end else begin
          hdr_d = hdr_q + scan_q.line_bytes + LEN_W'(2);
          if ((scan_q.phase == PH_TOKEN) &&
              (scan_q.match_idx == KEY_IDX_W'(KEY_LEN))) begin
            scan_d.content_len = '0;
            scan_d.len_seen    = 1'b1;
          end else if (scan_q.phase == PH_VALUE) begin
            scan_d.content_len = scan_q.acc;
            scan_d.len_seen    = 1'b1;
          end
          scan_d.phase      = PH_TOKEN;
          scan_d.match_idx  = '0;
          scan_d.has_bytes  = 1'b0;
          scan_d.line_bytes = '0;
          scan_d.acc        = '0;
        end
      end else begin
        // a held lone CR becomes a line byte: no digit, breaks a token
        if (cr_q) begin
          cr_d              = 1'b0;
          scan_d.line_bytes = scan_q.line_bytes + LEN_W'(1);
          scan_d.has_bytes  = 1'b1;
          if (scan_q.phase == PH_TOKEN) begin
            scan_d.phase = PH_REST;
          end
        end
        if (b == BYTE_CR) begin
          cr_d = 1'b1;
        end else begin
          scan_d = take_byte(scan_d, b);
        end
      end

      // buffer end or size limit
      if (!emit) begin
        taken = {1'b0, hdr_d} + {1'b0, scan_d.line_bytes} + {{LEN_W{1'b0}}, cr_d};
        if (last || (taken >= (LEN_W+1)'(MAX_MESSAGE_BYTES))) begin
          emit = 1'b1;
        end
      end

      if (emit) begin
        if (last) begin
          done_d = 1'b0;
        end else begin
          done_d = 1'b1;
        end
      end
    end

    res_o.total_size      = scan_d.content_len + {{(32-LEN_W){1'b0}}, hdr_d};
    res_o.length_found    = scan_d.len_seen;
    res_o.header_complete = complete;
    emit_o                = emit;

    // final byte after a result restarts the scan
    if (emit && last) begin
      scan_d = SCAN_RESET;
      hdr_d  = '0;
      cr_d   = 1'b0;
    end
  end

  // scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= SCAN_RESET;
      hdr_q  <= '0;
      cr_q   <= 1'b0;
      done_q <= 1'b0;
    end else if (advance_i) begin
      scan_q <= scan_d;
      hdr_q  <= hdr_d;
      cr_q   <= cr_d;
      done_q <= done_d;
    end
  end

endmodule

### design/rls_out_reg.sv
// ----------------------------------------------------------------------------
// rls_out_reg
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module rls_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  rls_pkg::result_t res_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [31:0]      total_size_o,
  output logic             length_found_o,
  output logic             header_complete_o
);
  import rls_pkg::*;

  logic    valid_q;
  result_t res_q;

  // can accept a new word this cycle
  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o       = valid_q;
  assign total_size_o      = res_q.total_size;
  assign length_found_o    = res_q.length_found;
  assign header_complete_o = res_q.header_complete;

endmodule
